FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the overtemperature detector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define OTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds on a rising edge of clk outside reset.
`define OTD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: sv/otd_pkg.sv
// ----------------------------------------------------------------------------
// otd_pkg
// Widths, constants and types of the smoothed overtemperature detector.
// ----------------------------------------------------------------------------
`default_nettype none

package otd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = SAMPLE_BITS;

    // 2*previous + 3*sample stays below 5 * 2**SAMPLE_BITS
    localparam int SUM_W       = SAMPLE_BITS + 3;
    localparam int PROD_W      = 2 * SUM_W;
    localparam int DIV5_SHIFT  = SUM_W + 2;
    localparam logic [SUM_W-1:0] DIV5_MUL = SUM_W'((2 ** DIV5_SHIFT + 4) / 5);

    localparam logic [SAMPLE_BITS-1:0] TRIP_RESET    = SAMPLE_BITS'(817);
    localparam logic [SAMPLE_BITS-1:0] CLEAR_RESET   = SAMPLE_BITS'(1112);
    localparam logic [COUNT_BITS-1:0]  QUALIFY_RESET = COUNT_BITS'(10);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIP_LEVEL    = 2'd0,
        CFG_CLEAR_LEVEL   = 2'd1,
        CFG_QUALIFY_COUNT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] trip_level;
        logic [SAMPLE_BITS-1:0] clear_level;
        logic [COUNT_BITS-1:0]  qualify_count;
    } cfg_t;

    typedef struct packed {
        logic active;
        logic raised;
        logic cleared;
    } trip_status_t;

endpackage

`default_nettype wire

FILE: sv/overtemp_detector_smoothed_core.sv
// ----------------------------------------------------------------------------
// overtemp_detector_smoothed_core
// Smoothed thermistor overtemperature detector with hysteresis.
// Each sample is held in the input register, then its result in the result register.
// Throughput: one sample per cycle unless out_ready stalls a result; input and
// result register each hold one transaction, so input is taken while a result waits.
// Reset clears the smoothed level, qualify counter, latch and both valid bits,
// and loads the configuration registers with their default levels.
// ----------------------------------------------------------------------------
`default_nettype none

module overtemp_detector_smoothed_core
    import otd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] adc_sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [SAMPLE_BITS-1:0] filtered_level,
    output logic                        overheat_active,
    output logic                        fault_raised,
    output logic                        fault_cleared,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_level_reg;
    trip_status_t           out_status_reg;
    logic                   advance;
    logic [SAMPLE_BITS-1:0] level_next;
    trip_status_t           status_next;
    cfg_t                   cfg;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    otd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    otd_smoother u_smoother (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .sample     (in_sample_reg),
        .level_next (level_next)
    );

    otd_trip_ctrl u_trip_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .level       (level_next),
        .cfg         (cfg),
        .status_next (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_sample_reg <= adc_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_level_reg  <= level_next;
            out_status_reg <= status_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_level  = out_level_reg;
    assign overheat_active = out_status_reg.active;
    assign fault_raised    = out_status_reg.raised;
    assign fault_cleared   = out_status_reg.cleared;

    `include "assert_macros.svh"

    `OTD_ASSERT(a_stalled_input_holds, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_sample_reg)), "stalled input transaction lost")
    `OTD_NEVER(a_result_pulses_exclusive, out_valid_reg && out_status_reg.raised && out_status_reg.cleared, "raise and clear in one result")

endmodule

`default_nettype wire

FILE: sv/otd_cfg_regs.sv
// ----------------------------------------------------------------------------
// otd_cfg_regs
// Configuration register file: trip level, clear level and qualify count.
// ----------------------------------------------------------------------------
`default_nettype none

module otd_cfg_regs
    import otd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TRIP_LEVEL:    cfg_next.trip_level    = cfg_data[SAMPLE_BITS-1:0];
                CFG_CLEAR_LEVEL:   cfg_next.clear_level   = cfg_data[SAMPLE_BITS-1:0];
                CFG_QUALIFY_COUNT: cfg_next.qualify_count = cfg_data[COUNT_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trip_level    <= TRIP_RESET;
            cfg_reg.clear_level   <= CLEAR_RESET;
            cfg_reg.qualify_count <= QUALIFY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/otd_smoother.sv
// ----------------------------------------------------------------------------
// otd_smoother
// Smoothed level: floor((2*previous + 3*sample) / 5), divide by reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module otd_smoother
    import otd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic      [SAMPLE_BITS-1:0] level_next
);

    logic [SAMPLE_BITS-1:0] level_reg;
    logic [SUM_W-1:0]       blend_sum;
    logic [PROD_W-1:0]      blend_prod;

    assign blend_sum  = (SUM_W'(level_reg) << 1) + (SUM_W'(sample) << 1) + SUM_W'(sample);
    assign blend_prod = PROD_W'(blend_sum) * PROD_W'(DIV5_MUL);
    assign level_next = SAMPLE_BITS'(blend_prod >> DIV5_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (advance)
        begin
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/otd_trip_ctrl.sv
// ----------------------------------------------------------------------------
// otd_trip_ctrl
// Qualify counter and overheat latch with trip and clear hysteresis.
// ----------------------------------------------------------------------------
`default_nettype none

module otd_trip_ctrl
    import otd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire logic [SAMPLE_BITS-1:0] level,
    input  wire cfg_t                   cfg,
    output trip_status_t                status_next
);

    logic [COUNT_BITS-1:0] counter_reg;
    logic [COUNT_BITS-1:0] counter_next;
    logic                  latched_reg;
    logic                  latched_next;

    always_comb
    begin
        counter_next        = counter_reg;
        latched_next        = latched_reg;
        status_next.raised  = 1'b0;
        status_next.cleared = 1'b0;
        if (!latched_reg && (level < cfg.trip_level))
        begin
            if (counter_reg > cfg.qualify_count)
            begin
                latched_next       = 1'b1;
                status_next.raised = 1'b1;
            end
            if (counter_reg != COUNT_MAX)
            begin
                counter_next = counter_reg + COUNT_BITS'(1);
            end
        end
        else if (latched_reg && (level > cfg.clear_level))
        begin
            counter_next        = '0;
            latched_next        = 1'b0;
            status_next.cleared = 1'b1;
        end
        status_next.active = latched_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            latched_reg <= 1'b0;
        end
        else if (advance)
        begin
            counter_reg <= counter_next;
            latched_reg <= latched_next;
        end
    end

    `include "assert_macros.svh"

    `OTD_ASSERT(a_latch_rise_on_advance, $rose(latched_reg) |-> $past(advance), "latch set without a transaction")
    `OTD_ASSERT(a_clear_zeroes_counter, $fell(latched_reg) |-> (counter_reg == '0), "counter not zeroed on clear")
    `OTD_ASSERT(a_rise_needs_count, $rose(latched_reg) |-> ($past(counter_reg) > $past(cfg.qualify_count)), "latch set before qualify count exceeded")

endmodule

`default_nettype wire
